>>> hw/rtl/bgc_pkg.sv
package bgc_pkg;

  localparam int TIME_BITS = 32;
  localparam int CFG_BITS  = 32;
  localparam int CMP_BITS  = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  typedef logic [TIME_BITS-1:0] tick_t;
  typedef logic [CFG_BITS-1:0]  cfg_word_t;
  typedef logic [CMP_BITS-1:0]  cmp_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_CLICK_MIN = 2'd1,
    REG_CLICK_MAX = 2'd2,
    REG_HOLD_MIN  = 2'd3
  } reg_index_t;

  localparam cfg_word_t DEBOUNCE_RST  = 32'd20;
  localparam cfg_word_t CLICK_MIN_RST = 32'd50;
  localparam cfg_word_t CLICK_MAX_RST = 32'd400;
  localparam cfg_word_t HOLD_MIN_RST  = 32'd1000;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_ENGAGED  = 2'd1,
    PH_WAIT_REL = 2'd2
  } phase_t;

  localparam logic [2:0] GST_NONE        = 3'd0;
  localparam logic [2:0] GST_CLICK       = 3'd1;
  localparam logic [2:0] GST_DOUBLE      = 3'd2;
  localparam logic [2:0] GST_TRIPLE      = 3'd3;
  localparam logic [2:0] GST_HOLD        = 3'd4;
  localparam logic [2:0] GST_TAP_HOLD    = 3'd5;
  localparam logic [2:0] GST_DOUBLE_HOLD = 3'd6;

  typedef struct packed {
    cfg_word_t debounce_time;
    cfg_word_t click_min_time;
    cfg_word_t click_max_time;
    cfg_word_t hold_min_time;
  } timing_t;

  function automatic cmp_t widen_tick(input tick_t t);
    return CMP_BITS'(t);
  endfunction

  function automatic cmp_t widen_cfg(input cfg_word_t c);
    return CMP_BITS'(c);
  endfunction

  function automatic logic [2:0] tap_code(input logic [1:0] n);
    case (n)
      2'd0:    return GST_NONE;
      2'd1:    return GST_CLICK;
      2'd2:    return GST_DOUBLE;
      default: return GST_TRIPLE;
    endcase
  endfunction

  function automatic logic [2:0] hold_code(input logic [1:0] n);
    case (n)
      2'd0:    return GST_HOLD;
      2'd1:    return GST_TAP_HOLD;
      default: return GST_DOUBLE_HOLD;
    endcase
  endfunction

endpackage

>>> hw/rtl/bgc_filter.sv
module bgc_filter (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                level,
  input  bgc_pkg::tick_t      now,
  input  bgc_pkg::cfg_word_t  debounce_time,
  output logic                pass
);
  import bgc_pkg::*;

  logic  filter_level;
  tick_t filter_time;
  logic  filter_pending;
  logic  filter_pending_next;
  logic  changed;
  tick_t delta;

  assign changed = level != filter_level;
  assign delta   = now - filter_time;

  always_comb begin
    if (filter_pending && (widen_tick(delta) < widen_cfg(debounce_time))) begin
      pass                = 1'b0;
      filter_pending_next = filter_pending;
    end else if (changed && !filter_pending) begin
      pass                = 1'b0;
      filter_pending_next = 1'b1;
    end else begin
      pass                = 1'b1;
      filter_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_level   <= 1'b1;
      filter_time    <= '0;
      filter_pending <= 1'b0;
    end else if (step) begin
      filter_pending <= filter_pending_next;
      if (changed) begin
        filter_level <= level;
        filter_time  <= now;
      end
    end
  end

endmodule

>>> hw/rtl/bgc_gesture.sv
module bgc_gesture (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             level,
  input  bgc_pkg::tick_t   now,
  input  bgc_pkg::timing_t timing,
  output logic [2:0]       code
);
  import bgc_pkg::*;

  logic       stable_level;
  tick_t      stable_time;
  phase_t     phase;
  phase_t     phase_next;
  logic [1:0] click_count;
  logic [1:0] click_count_next;
  logic [1:0] count_sat;
  logic       changed;
  tick_t      delta;
  cmp_t       delta_w;
  logic       lt_min;
  logic       lt_max;
  logic       gt_max;
  logic       gt_hold;

  assign changed   = level != stable_level;
  assign delta     = now - stable_time;
  assign delta_w   = widen_tick(delta);
  assign lt_min    = delta_w < widen_cfg(timing.click_min_time);
  assign lt_max    = delta_w < widen_cfg(timing.click_max_time);
  assign gt_max    = delta_w > widen_cfg(timing.click_max_time);
  assign gt_hold   = delta_w > widen_cfg(timing.hold_min_time);
  assign count_sat = (click_count == 2'd3) ? click_count : click_count + 2'd1;

  always_comb begin
    phase_next = phase;
    if (changed) begin
      case (phase)
        PH_IDLE:     phase_next = PH_ENGAGED;
        PH_WAIT_REL: phase_next = PH_IDLE;
        default: begin
          if (level && (lt_min || gt_max)) begin
            phase_next = PH_IDLE;
          end
        end
      endcase
    end else if (phase == PH_ENGAGED && !lt_min) begin
      if (level && gt_max) begin
        phase_next = PH_IDLE;
      end else if (!level && gt_hold) begin
        phase_next = PH_WAIT_REL;
      end
    end
  end

  always_comb begin
    click_count_next = click_count;
    code             = GST_NONE;
    if (changed) begin
      case (phase)
        PH_IDLE:     click_count_next = 2'd0;
        PH_WAIT_REL: click_count_next = 2'd0;
        default: begin
          if (level) begin
            if (lt_min || gt_max) begin
              if (gt_max) begin
                click_count_next = count_sat;
              end
              code = tap_code(gt_max ? count_sat : click_count);
            end else begin
              click_count_next = count_sat;
            end
          end else if (!lt_max && click_count != 2'd0) begin
            code             = tap_code(click_count);
            click_count_next = 2'd0;
          end
        end
      endcase
    end else if (phase == PH_ENGAGED && !lt_min) begin
      if (level && gt_max) begin
        code             = tap_code(click_count);
        click_count_next = 2'd0;
      end else if (!level && gt_hold) begin
        code             = hold_code(click_count);
        click_count_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= 1'b1;
      stable_time  <= '0;
      phase        <= PH_IDLE;
      click_count  <= 2'd0;
    end else if (step) begin
      phase       <= phase_next;
      click_count <= click_count_next;
      if (changed) begin
        stable_level <= level;
        stable_time  <= now;
      end
    end
  end

endmodule

>>> hw/rtl/button_gesture_classifier_core.sv
// An accepted item enters the poll register; its gesture is registered once
// the output is free. Throughput: one item per cycle while out_ready is high;
// the filter and phase machine are combinational, so items stream back to back.
// Reset (rst, synchronous): timing registers return to their defaults, the
// filter and stable levels to released, the phase machine to idle.
module button_gesture_classifier_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                button_level,
  input  logic [31:0]         time_now,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          gesture,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bgc_pkg::reg_index_t cfg_index,
  input  bgc_pkg::cfg_word_t  cfg_data
);
  import bgc_pkg::*;

  timing_t    timing;
  logic       poll_valid;
  logic       poll_level;
  tick_t      poll_time;
  logic       advance;
  logic       pass;
  logic [2:0] gesture_code;

  assign cfg_ready = 1'b1;
  assign advance   = poll_valid && (!out_valid || out_ready);
  assign in_ready  = !poll_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.debounce_time  <= DEBOUNCE_RST;
      timing.click_min_time <= CLICK_MIN_RST;
      timing.click_max_time <= CLICK_MAX_RST;
      timing.hold_min_time  <= HOLD_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:  timing.debounce_time  <= cfg_data;
        REG_CLICK_MIN: timing.click_min_time <= cfg_data;
        REG_CLICK_MAX: timing.click_max_time <= cfg_data;
        REG_HOLD_MIN:  timing.hold_min_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (in_ready) begin
      poll_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_level <= button_level;
      poll_time  <= TIME_BITS'(time_now);
    end
  end

  bgc_filter u_filter (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .level         (poll_level),
    .now           (poll_time),
    .debounce_time (timing.debounce_time),
    .pass          (pass)
  );

  bgc_gesture u_gesture (
    .clk    (clk),
    .rst    (rst),
    .step   (advance && pass),
    .level  (poll_level),
    .now    (poll_time),
    .timing (timing),
    .code   (gesture_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture <= pass ? gesture_code : GST_NONE;
    end
  end

endmodule
